FILE: rtl/core/blas_pkg.sv
`default_nettype none
package blas_pkg;

  localparam int BLAS_COORD_FRAC_BITS = 8;
  localparam int BLAS_CORDIC_STAGES   = 20;

  localparam int BLAS_CRD_XTRA_LAT = 4;
  localparam int BLAS_CRD_NORM_MSB = 29;
  localparam int BLAS_CRD_W        = 33;
  localparam int BLAS_CRD_Z_W      = 28;
  localparam int BLAS_CODE_W       = 17;
  localparam int BLAS_HALF_TURN    = 180 * 65536;
  localparam int BLAS_RND_BIAS     = 256;
  localparam int BLAS_RND_SH       = 9;
  localparam int BLAS_YAW_LIM      = 23040;
  localparam int BLAS_PITCH_LIM    = 11520;
  localparam int BLAS_GRAV_CM      = 981;

  localparam logic [21:0] BLAS_CRD_ATAN [32] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
    22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2,
    22'd1, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0
  };

  localparam logic BLAS_REG_SPEED  = 1'b0;
  localparam logic BLAS_REG_GSCALE = 1'b1;

  localparam logic [1:0] BLAS_CNT_NONE = 2'd0;
  localparam logic [1:0] BLAS_CNT_ONE  = 2'd1;
  localparam logic [1:0] BLAS_CNT_TWO  = 2'd2;

  function automatic logic signed [BLAS_CODE_W-1:0] blas_clamp(
    input logic signed [BLAS_CODE_W-1:0] v,
    input logic signed [BLAS_CODE_W-1:0] lim
  );
    logic signed [BLAS_CODE_W-1:0] r;
    r = v;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/blas_sqrt.sv
`default_nettype none
module blas_sqrt #(
  parameter int IN_W = 118
) (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [IN_W-1:0]     rad_i,
  output logic      [IN_W/2-1:0]   root_o
);

  localparam int RW = IN_W / 2;

  logic [IN_W-1:0] rem_q  [RW];
  logic [RW-1:0]   root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_bit
    localparam int B = RW - 1 - k;
    logic [IN_W-1:0] rem_in;
    logic [RW-1:0]   root_in;
    logic [IN_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign trial = (IN_W'(root_in) << (B + 1)) | (IN_W'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[k]  <= rem_in - trial;
          root_q[k] <= root_in | (RW'(1) << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule
`default_nettype wire

FILE: rtl/core/blas_cordic.sv
`default_nettype none
module blas_cordic
  import blas_pkg::*;
#(
  parameter int MAG_W  = 60,
  parameter int STAGES = BLAS_CORDIC_STAGES
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic                          y_neg_i,
  input  wire logic [MAG_W-1:0]              y_mag_i,
  input  wire logic                          x_neg_i,
  input  wire logic [MAG_W-1:0]              x_mag_i,
  output logic signed [BLAS_CODE_W-1:0]      code_o
);

  localparam int POS_W = $clog2(MAG_W);
  localparam int NW    = BLAS_CRD_NORM_MSB + 1;
  localparam int CW    = BLAS_CRD_W;
  localparam int ZW    = BLAS_CRD_Z_W;
  localparam logic [POS_W-1:0] NORM = POS_W'(BLAS_CRD_NORM_MSB);
  localparam logic signed [ZW-1:0] HALF = ZW'(BLAS_HALF_TURN);

  logic             yn1_q, xn1_q, zero1_q;
  logic [MAG_W-1:0] ym1_q, xm1_q, max1_q;

  logic             yn2_q, xn2_q, zero2_q;
  logic [MAG_W-1:0] ym2_q, xm2_q;
  logic [POS_W-1:0] msb2_q;
  logic [POS_W-1:0] msb_d;

  logic [MAG_W-1:0]     xsh, ysh;
  logic [NW-1:0]        xv, yv;
  logic signed [CW-1:0] y0;
  logic signed [ZW-1:0] z0;

  logic signed [CW-1:0] xs_q [STAGES+1];
  logic signed [CW-1:0] ys_q [STAGES+1];
  logic signed [ZW-1:0] zs_q [STAGES+1];
  logic                 zf_q [STAGES+1];

  logic signed [ZW-1:0] zf;
  logic [ZW-1:0]        zmag, zrnd;

  // stage 1: larger magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yn1_q   <= y_neg_i;
      xn1_q   <= x_neg_i;
      ym1_q   <= y_mag_i;
      xm1_q   <= x_mag_i;
      max1_q  <= (x_mag_i > y_mag_i) ? x_mag_i : y_mag_i;
      zero1_q <= (x_mag_i == '0) && (y_mag_i == '0);
    end
  end

  // stage 2: leading one position
  always_comb begin
    msb_d = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (max1_q[i]) begin
        msb_d = POS_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yn2_q   <= yn1_q;
      xn2_q   <= xn1_q;
      ym2_q   <= ym1_q;
      xm2_q   <= xm1_q;
      zero2_q <= zero1_q;
      msb2_q  <= msb_d;
    end
  end

  // stage 3: normalize, fold left half plane
  always_comb begin
    if (msb2_q > NORM) begin
      xsh = xm2_q >> (msb2_q - NORM);
      ysh = ym2_q >> (msb2_q - NORM);
    end else begin
      xsh = xm2_q << (NORM - msb2_q);
      ysh = ym2_q << (NORM - msb2_q);
    end
    xv = xsh[NW-1:0];
    yv = ysh[NW-1:0];
    y0 = (yn2_q ^ xn2_q) ? -$signed(CW'(yv)) : $signed(CW'(yv));
    if (!xn2_q) begin
      z0 = '0;
    end else if (yn2_q && (yv != '0)) begin
      z0 = -HALF;
    end else begin
      z0 = HALF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_q[0] <= $signed(CW'(xv));
      ys_q[0] <= y0;
      zs_q[0] <= z0;
      zf_q[0] <= zero2_q;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ANG = ZW'(BLAS_CRD_ATAN[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zf_q[i+1] <= zf_q[i];
        if (ys_q[i] > 0) begin
          xs_q[i+1] <= xs_q[i] + (ys_q[i] >>> i);
          ys_q[i+1] <= ys_q[i] - (xs_q[i] >>> i);
          zs_q[i+1] <= zs_q[i] + ANG;
        end else begin
          xs_q[i+1] <= xs_q[i] - (ys_q[i] >>> i);
          ys_q[i+1] <= ys_q[i] + (xs_q[i] >>> i);
          zs_q[i+1] <= zs_q[i] - ANG;
        end
      end
    end
  end

  // round half away from zero to 1/128 degree
  always_comb begin
    zf   = zs_q[STAGES];
    zmag = (zf < 0) ? ZW'(-zf) : ZW'(zf);
    zrnd = (zmag + ZW'(BLAS_RND_BIAS)) >> BLAS_RND_SH;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zf_q[STAGES]) begin
        code_o <= '0;
      end else if (zf < 0) begin
        code_o <= -$signed(zrnd[BLAS_CODE_W-1:0]);
      end else begin
        code_o <= $signed(zrnd[BLAS_CODE_W-1:0]);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ballistic_launch_angle_solver_unit.sv
// channel   dir  width  payload
// s_axis    in   192    target_x, target_y, target_z, source_x, source_y, source_z
// m_axis    out  48     solution_count, aim_yaw, low_pitch, high_pitch
// cfg       in   16     launch_speed (index 0), gravity_scale (index 1)
//
// one item per cycle while the output item is empty or taken; the two square
// root pipelines resolve one root bit per stage, and their root width RW is 59
// at the default format; the cordic pipelines have 20 rotation stages by default
// reset clears the valid chain and presets the config registers (speed 0, gravity scale 4096) only
// the whole pipeline holds while the output item waits and is not taken
`default_nettype none
module ballistic_launch_angle_solver_unit
  import blas_pkg::*;
#(
  parameter int COORD_FRAC_BITS = BLAS_COORD_FRAC_BITS,
  parameter int CORDIC_STAGES   = BLAS_CORDIC_STAGES
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // target_x, target_y, target_z, source_x, source_y, source_z
  input  wire logic [191:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // solution_count, aim_yaw, low_pitch, high_pitch
  output logic [47:0]        m_axis_tdata,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [15:0]   cfg_wdata_i
);

  localparam int SH     = 12 + COORD_FRAC_BITS;
  localparam int T1_W   = 64 + 2 * SH;
  localparam int T2_W   = 117;
  localparam int T3_W   = 92 + SH;
  localparam int MAX12  = (T1_W > T2_W) ? T1_W : T2_W;
  localparam int MAXW   = (MAX12 > T3_W) ? MAX12 : T3_W;
  localparam int WIDE_W = ((MAXW + 2) / 2) * 2;
  localparam int RW     = WIDE_W / 2;
  localparam int MW     = RW + 1;
  localparam int LC     = CORDIC_STAGES + BLAS_CRD_XTRA_LAT;
  localparam int SP     = RW + 10;
  localparam int YD     = SP - 2;
  localparam int OD     = SP + LC - 9;
  localparam int LAT    = SP + LC + 1;
  localparam int CDW    = BLAS_CODE_W;

  localparam logic signed [CDW-1:0] YAW_LIM   = CDW'(BLAS_YAW_LIM);
  localparam logic signed [CDW-1:0] PITCH_LIM = CDW'(BLAS_PITCH_LIM);

  // config and derived constants
  logic [15:0] speed_q, gscale_q;
  logic [25:0] g_q;
  logic [31:0] s2_q;
  logic [51:0] g2_q;
  logic [57:0] gs2_q;
  logic [63:0] s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= 16'd0;
      gscale_q <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        BLAS_REG_SPEED:  speed_q  <= cfg_wdata_i;
        BLAS_REG_GSCALE: gscale_q <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    g_q   <= 26'(BLAS_GRAV_CM * gscale_q);
    s2_q  <= speed_q * speed_q;
    g2_q  <= g_q * g_q;
    gs2_q <= g_q * s2_q;
    s4_q  <= s2_q * s2_q;
  end

  // handshake
  logic [LAT-1:0] vld_q;
  logic           en;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  logic signed [31:0] tx, ty, tz, sx, sy, sz;
  assign tx = s_axis_tdata[31:0];
  assign ty = s_axis_tdata[63:32];
  assign tz = s_axis_tdata[95:64];
  assign sx = s_axis_tdata[127:96];
  assign sy = s_axis_tdata[159:128];
  assign sz = s_axis_tdata[191:160];

  logic signed [32:0] dx1_q, dy1_q, dz1_q;
  logic [32:0]        adx2_q, ady2_q, adz2_q;
  logic               dxn2_q, dyn2_q, dzn2_q, dzp2_q;
  logic [65:0]        ax2_3_q, ay2_3_q;
  logic [61:0]        t3lo_3_q, t3hi_3_q;
  logic               dzn3_q, dzp3_q;
  logic [65:0]        x2_4_q;
  logic [90:0]        t3s_4_q;
  logic               dzn4_q, dzp4_q;
  logic [58:0]        pp00_q, pp01_q, pp10_q, pp11_q;
  logic [WIDE_W-1:0]  t3_5_q, t3_6_q, t3_7_q;
  logic               dzn5_q, dzp5_q, dzn6_q, dzp6_q, dzn7_q, dzp7_q;
  logic [85:0]        a6_q, b6_q;
  logic [WIDE_W-1:0]  t2_7_q, t2_8_q, t2_9_q;
  logic [WIDE_W-1:0]  pos8_q, neg8_q, diff9_q;
  logic               ok9_q;
  logic [WIDE_W-1:0]  t1;
  logic [WIDE_W:0]    sub9;

  assign t1   = WIDE_W'(s4_q) << (2 * SH);
  assign sub9 = {1'b0, pos8_q} - {1'b0, neg8_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q <= 33'(tx) - 33'(sx);
      dy1_q <= 33'(ty) - 33'(sy);
      dz1_q <= 33'(tz) - 33'(sz);

      adx2_q <= dx1_q[32] ? 33'(-dx1_q) : 33'(dx1_q);
      ady2_q <= dy1_q[32] ? 33'(-dy1_q) : 33'(dy1_q);
      adz2_q <= dz1_q[32] ? 33'(-dz1_q) : 33'(dz1_q);
      dxn2_q <= dx1_q[32];
      dyn2_q <= dy1_q[32];
      dzn2_q <= dz1_q[32];
      dzp2_q <= !dz1_q[32] && (dz1_q != '0);

      ax2_3_q  <= adx2_q * adx2_q;
      ay2_3_q  <= ady2_q * ady2_q;
      t3lo_3_q <= gs2_q[28:0] * adz2_q;
      t3hi_3_q <= gs2_q[57:29] * adz2_q;
      dzn3_q   <= dzn2_q;
      dzp3_q   <= dzp2_q;

      x2_4_q  <= ax2_3_q + ay2_3_q;
      t3s_4_q <= 91'(t3lo_3_q) + (91'(t3hi_3_q) << 29);
      dzn4_q  <= dzn3_q;
      dzp4_q  <= dzp3_q;

      pp00_q <= x2_4_q[32:0] * g2_q[25:0];
      pp01_q <= x2_4_q[32:0] * g2_q[51:26];
      pp10_q <= x2_4_q[65:33] * g2_q[25:0];
      pp11_q <= x2_4_q[65:33] * g2_q[51:26];
      t3_5_q <= WIDE_W'(t3s_4_q) << (SH + 1);
      dzn5_q <= dzn4_q;
      dzp5_q <= dzp4_q;

      a6_q   <= 86'(pp00_q) + (86'(pp01_q) << 26);
      b6_q   <= 86'(pp10_q) + (86'(pp11_q) << 26);
      t3_6_q <= t3_5_q;
      dzn6_q <= dzn5_q;
      dzp6_q <= dzp5_q;

      t2_7_q <= WIDE_W'((120'(b6_q) << 33) + 120'(a6_q));
      t3_7_q <= t3_6_q;
      dzn7_q <= dzn6_q;
      dzp7_q <= dzp6_q;

      pos8_q <= t1 + (dzn7_q ? t3_7_q : '0);
      neg8_q <= t2_7_q + (dzp7_q ? t3_7_q : '0);
      t2_8_q <= t2_7_q;

      ok9_q   <= !sub9[WIDE_W];
      diff9_q <= sub9[WIDE_W] ? '0 : sub9[WIDE_W-1:0];
      t2_9_q  <= t2_8_q;
    end
  end

  // square roots of discriminant and of (g x)^2
  logic [RW-1:0] r_root, q_root;

  blas_sqrt #(.IN_W(WIDE_W)) u_sqrt_disc (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (diff9_q),
    .root_o (r_root)
  );

  blas_sqrt #(.IN_W(WIDE_W)) u_sqrt_gx (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (t2_9_q),
    .root_o (q_root)
  );

  // pitch operands
  logic [MW-1:0] p_w, r_ext, rp;
  logic [MW:0]   sub_pr;
  logic          lnp_q;
  logic [MW-1:0] lmp_q, hip_q, qp_q;

  assign p_w    = MW'(s2_q) << SH;
  assign r_ext  = MW'(r_root);
  assign sub_pr = {1'b0, p_w} - {1'b0, r_ext};
  assign rp     = r_ext - p_w;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lnp_q <= sub_pr[MW];
      lmp_q <= sub_pr[MW] ? rp : sub_pr[MW-1:0];
      hip_q <= p_w + r_ext;
      qp_q  <= MW'(q_root);
    end
  end

  logic signed [CDW-1:0] yaw_code, low_code, high_code;

  blas_cordic #(.MAG_W(MW), .STAGES(CORDIC_STAGES)) u_cordic_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_neg_i (dyn2_q),
    .y_mag_i (MW'(ady2_q)),
    .x_neg_i (dxn2_q),
    .x_mag_i (MW'(adx2_q)),
    .code_o  (yaw_code)
  );

  blas_cordic #(.MAG_W(MW), .STAGES(CORDIC_STAGES)) u_cordic_low (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_neg_i (lnp_q),
    .y_mag_i (lmp_q),
    .x_neg_i (1'b0),
    .x_mag_i (qp_q),
    .code_o  (low_code)
  );

  blas_cordic #(.MAG_W(MW), .STAGES(CORDIC_STAGES)) u_cordic_high (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_neg_i (1'b0),
    .y_mag_i (hip_q),
    .x_neg_i (1'b0),
    .x_mag_i (qp_q),
    .code_o  (high_code)
  );

  // align heading and discriminant sign with the pitch lanes
  logic signed [CDW-1:0] yaw_dl_q [YD];
  logic                  ok_dl_q  [OD];

  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_dl_q[0] <= yaw_code;
      for (int k = 1; k < YD; k++) begin
        yaw_dl_q[k] <= yaw_dl_q[k-1];
      end
      ok_dl_q[0] <= ok9_q;
      for (int k = 1; k < OD; k++) begin
        ok_dl_q[k] <= ok_dl_q[k-1];
      end
    end
  end

  // result
  logic signed [CDW-1:0] yaw_c, low_c, high_c;
  logic [1:0]            cnt_q;
  logic [15:0]           yaw_q;
  logic [14:0]           low_q, high_q;

  assign yaw_c  = blas_clamp(yaw_dl_q[YD-1], YAW_LIM);
  assign low_c  = blas_clamp(low_code, PITCH_LIM);
  assign high_c = blas_clamp(high_code, PITCH_LIM);

  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_q <= yaw_c[15:0];
      if (!ok_dl_q[OD-1]) begin
        cnt_q  <= BLAS_CNT_NONE;
        low_q  <= '0;
        high_q <= '0;
      end else if (low_c == high_c) begin
        cnt_q  <= BLAS_CNT_ONE;
        low_q  <= low_c[14:0];
        high_q <= '0;
      end else begin
        cnt_q  <= BLAS_CNT_TWO;
        low_q  <= low_c[14:0];
        high_q <= high_c[14:0];
      end
    end
  end

  assign m_axis_tdata = {high_q, low_q, yaw_q, cnt_q};

endmodule
`default_nettype wire

FILE: tb/tb_ballistic_launch_angle_solver_unit.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_ballistic_launch_angle_solver_unit;
  import blas_pkg::*;

  typedef struct packed {
    logic signed [31:0] src_z;
    logic signed [31:0] src_y;
    logic signed [31:0] src_x;
    logic signed [31:0] tgt_z;
    logic signed [31:0] tgt_y;
    logic signed [31:0] tgt_x;
  } aim_req_t;

  typedef struct packed {
    logic signed [14:0] high_pitch;
    logic signed [14:0] low_pitch;
    logic signed [15:0] yaw;
    logic [1:0]         count;
  } aim_sol_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [47:0]  m_axis_tdata;
  logic         cfg_we_i;
  logic         cfg_idx_i;
  logic [15:0]  cfg_wdata_i;

  aim_req_t req_queue[$];
  aim_sol_t sol_queue[$];
  logic [15:0] cur_speed;
  logic [15:0] cur_gscale;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          err_count;

  ballistic_launch_angle_solver_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint unsigned isqrt(logic [127:0] n);
    longint unsigned r;
    longint unsigned t;
    logic [127:0] sq;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      sq = {64'd0, t} * {64'd0, t};
      if (sq <= n) r = t;
    end
    return r;
  endfunction

  // vectoring cordic, angle in 1/128 degree
  function automatic longint angle_code(bit yn, longint unsigned ym, bit xn,
                                        longint unsigned xm);
    longint unsigned m;
    longint x, y, z, base, total, xs, ys;
    z = 0;
    base = 0;
    if (xm == 0 && ym == 0) return 0;
    m = (xm > ym) ? xm : ym;
    while (m >= (64'd1 << 30)) begin
      xm >>= 1; ym >>= 1; m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      xm <<= 1; ym <<= 1; m <<= 1;
    end
    x = longint'(xm);
    y = yn ? -longint'(ym) : longint'(ym);
    if (xn) begin
      y = -y;
      base = (yn && ym != 0) ? -longint'(BLAS_HALF_TURN) : longint'(BLAS_HALF_TURN);
    end
    for (int i = 0; i < BLAS_CORDIC_STAGES && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(BLAS_CRD_ATAN[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(BLAS_CRD_ATAN[i]);
      end
    end
    total = base + z;
    if (total < 0) return -((-total + BLAS_RND_BIAS) >>> BLAS_RND_SH);
    return (total + BLAS_RND_BIAS) >>> BLAS_RND_SH;
  endfunction

  function automatic aim_sol_t solve_aim(aim_req_t r);
    aim_sol_t o;
    longint dx, dy, dz, yaw, lowp, highp;
    longint unsigned adx, ady, adz, g, s2, rt, p, q, lm;
    logic [127:0] x2, t1, t2, t3, pos, neg;
    bit ln;
    dx = longint'(r.tgt_x) - longint'(r.src_x);
    dy = longint'(r.tgt_y) - longint'(r.src_y);
    dz = longint'(r.tgt_z) - longint'(r.src_z);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    adz = (dz < 0) ? -dz : dz;
    g = 64'(BLAS_GRAV_CM) * cur_gscale;
    s2 = 64'(cur_speed) * cur_speed;
    x2 = {64'd0, adx} * {64'd0, adx} + {64'd0, ady} * {64'd0, ady};
    t1 = ({64'd0, s2} * {64'd0, s2}) << (2 * (12 + BLAS_COORD_FRAC_BITS));
    t2 = x2 * {64'd0, g * g};
    t3 = ({64'd0, 64'd2 * g * s2} * {64'd0, adz}) << (12 + BLAS_COORD_FRAC_BITS);
    pos = t1;
    neg = t2;
    if (dz < 0) pos += t3;
    else if (dz > 0) neg += t3;
    yaw = clip(angle_code(dy < 0, ady, dx < 0, adx), BLAS_YAW_LIM);
    lowp = 0;
    highp = 0;
    o.count = BLAS_CNT_NONE;
    if (neg <= pos) begin
      rt = isqrt(pos - neg);
      p = s2 << (12 + BLAS_COORD_FRAC_BITS);
      q = isqrt(t2);
      ln = p < rt;
      lm = ln ? rt - p : p - rt;
      lowp = clip(angle_code(ln, lm, 1'b0, q), BLAS_PITCH_LIM);
      highp = clip(angle_code(1'b0, p + rt, 1'b0, q), BLAS_PITCH_LIM);
      if (lowp == highp) begin
        o.count = BLAS_CNT_ONE;
        highp = 0;
      end else begin
        o.count = BLAS_CNT_TWO;
      end
    end
    o.yaw = yaw[15:0];
    o.low_pitch = lowp[14:0];
    o.high_pitch = highp[14:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sol_queue.insert(sol_queue.size(), solve_aim(req_queue[0]));
        req_queue.pop_front();
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= req_queue[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    aim_sol_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (sol_queue.size() == 0) begin
          report_mismatch("unexpected item", got, 0);
        end else begin
          want = sol_queue.pop_front();
          if (got.count !== want.count) report_mismatch("count", got.count, want.count);
          if (got.yaw !== want.yaw) report_mismatch("yaw", got.yaw, want.yaw);
          if (got.low_pitch !== want.low_pitch)
            report_mismatch("low_pitch", got.low_pitch, want.low_pitch);
          if (got.high_pitch !== want.high_pitch)
            report_mismatch("high_pitch", got.high_pitch, want.high_pitch);
        end
      end
    end
  end

  function automatic aim_req_t mk_req(longint tx, longint ty, longint tz,
                                      longint sx, longint sy, longint sz);
    aim_req_t r;
    r.tgt_x = tx[31:0]; r.tgt_y = ty[31:0]; r.tgt_z = tz[31:0];
    r.src_x = sx[31:0]; r.src_y = sy[31:0]; r.src_z = sz[31:0];
    return r;
  endfunction

  function automatic logic [31:0] near_offset(logic [31:0] base);
    int k;
    logic [31:0] d;
    k = $urandom_range(24);
    d = $urandom_range((1 << k) - 1);
    return $urandom_range(1) ? base + d : base - d;
  endfunction

  function automatic aim_req_t rand_req();
    aim_req_t r;
    r.src_x = $urandom; r.src_y = $urandom; r.src_z = $urandom;
    if ($urandom_range(99) < 15) begin
      r.tgt_x = $urandom; r.tgt_y = $urandom; r.tgt_z = $urandom;
    end else begin
      r.tgt_x = near_offset(r.src_x);
      r.tgt_y = near_offset(r.src_y);
      r.tgt_z = near_offset(r.src_z);
    end
    return r;
  endfunction

  task automatic add_req(aim_req_t r);
    req_queue.insert(req_queue.size(), r);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == BLAS_REG_SPEED) cur_speed = val;
    else cur_gscale = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (req_queue.size() > 0 || sol_queue.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (110) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] speeds [6];
    logic [15:0] gscales [6];
    int max_x;
    speeds = '{16'd0, 16'd3000, 16'd65535, 16'd65535, 16'd1000, 16'd2000};
    gscales = '{16'd4096, 16'd4096, 16'd65535, 16'd0, 16'd1, 16'd8192};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = BLAS_REG_SPEED;
    cfg_wdata_i = '0;
    cur_speed = 16'd0;
    cur_gscale = 16'd4096;
    err_count = 0;
    send_idle_pct = 18;
    recv_idle_pct = 51;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 18; recv_idle_pct = 51; end
        1: begin send_idle_pct = 51; recv_idle_pct = 18; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph > 0) begin
        write_cfg(BLAS_REG_SPEED, speeds[ph]);
        write_cfg(BLAS_REG_GSCALE, gscales[ph]);
      end
      if (ph == 1) begin
        // max range on flat ground: s^2/g in q8 cm
        max_x = int'((64'd3000 * 3000 * 256) / 981);
        add_req(mk_req(0, 0, 0, 0, 0, 0));
        add_req(mk_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h80000000, 32'h80000000, 32'h80000000));
        add_req(mk_req(32'h80000000, 32'h80000000, 32'h80000000,
                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        add_req(mk_req(32'hffffffff, 0, 0, 0, 0, 0));
        add_req(mk_req(256000, 0, 0, 0, 0, 0));
        add_req(mk_req(-256000, 0, 0, 0, 0, 0));
        add_req(mk_req(0, 256000, 0, 0, 0, 0));
        add_req(mk_req(0, -256000, 0, 0, 0, 0));
        add_req(mk_req(-256000, -256000, 100000, 0, 0, 0));
        add_req(mk_req(-256000, 0, 0, 0, 0, 0));
        add_req(mk_req(0, 0, 256000, 0, 0, 0));
        add_req(mk_req(0, 0, -256000, 0, 0, 0));
        add_req(mk_req(0, 0, 3000000, 0, 0, 0));
        add_req(mk_req(max_x, 0, 0, 0, 0, 0));
        add_req(mk_req(max_x + 1, 0, 0, 0, 0, 0));
        add_req(mk_req(max_x - 1, 0, 0, 0, 0, 0));
        add_req(mk_req(max_x + 100000, 0, 0, 0, 0, 0));
        add_req(mk_req(1000, 1000, -2000000, 5000, 3000, 1000));
        add_req(mk_req(1, 0, 0, 0, 0, 0));
        add_req(mk_req(0, 1, 0, 0, 0, 0));
      end
      for (int n = 0; n < 215; n++) add_req(rand_req());
      drain();
    end
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
